FILE: rtl/wmc_pkg.sv
// Package for the windowed miss counter: sizes, register indexes, finish causes
// and the structs that travel between the front end, the queue and the back end.
// No dependencies.
package wmc_pkg;

    // Window length and the widths that follow from it.
    localparam int WINDOW      = 500;
    localparam int POS_W       = $clog2(WINDOW);
    localparam int CNT_W       = $clog2(WINDOW + 1);

    // Fixed field widths.
    localparam int LAT_W       = 32;
    localparam int TARGET_W    = 12;
    localparam int LIMIT_W     = 32;
    localparam int OUT_CNT_W   = 9;
    localparam int CAUSE_W     = 2;
    localparam int CMP_W       = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

    // Configuration port.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MISS_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT   = 2'd2;

    // Queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_RUNNING = 2'd0,
        CAUSE_TARGET  = 2'd1,
        CAUSE_TIMEOUT = 2'd2
    } cause_t;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // A classified request: the start flag and the miss bit.
    typedef struct packed {
        logic start;
        logic miss;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_slot_t;

endpackage

FILE: rtl/wmc_in_if.sv
// Input channel of the windowed miss counter: one latency sample per request.
// Depends on wmc_pkg.
interface wmc_in_if;
    logic                      valid;
    logic                      ready;
    logic                      start_req;
    logic [wmc_pkg::LAT_W-1:0] latency;

    modport source (output valid, output start_req, output latency, input ready);
    modport sink   (input valid, input start_req, input latency, output ready);
endinterface

FILE: rtl/wmc_out_if.sv
// Output channel of the windowed miss counter: the state after each request.
// Depends on wmc_pkg.
interface wmc_out_if;
    logic                          valid;
    logic                          ready;
    logic [wmc_pkg::OUT_CNT_W-1:0] window_misses;
    logic [wmc_pkg::OUT_CNT_W-1:0] peak_misses;
    logic                          finished;
    logic [wmc_pkg::CAUSE_W-1:0]   finish_cause;

    modport source (output valid, output window_misses, output peak_misses,
                    output finished, output finish_cause, input ready);
    modport sink   (input valid, input window_misses, input peak_misses,
                    input finished, input finish_cause, output ready);
endinterface

FILE: rtl/windowed_miss_counter.sv
// Top level of the windowed miss counter: configuration registers, front end,
// queue and back end. Depends on wmc_pkg, wmc_in_if, wmc_out_if and the submodules.
//
// Usage:
//   samples carries one request per latency sample (start_req, latency);
//   results returns one request per sample with the window miss count, the
//   peak count since start, the finished flag and the finish cause.
//   Configuration is written through cfg_we / cfg_index / cfg_data while the
//   block is idle: index 0 miss threshold, 1 target count, 2 sample limit.
// Timing:
//   A result is registered in the output register once its sample has passed through the queue.
//   Throughput is one sample per cycle while results.ready stays high; the ring update is one read-modify-write
//   of a single ring entry, and the next entry is prefetched from the ring
//   memory's registered read port so a sample can follow every cycle.
// Reset and stalls:
//   Reset clears all counters, the finish state and the configuration. The ring
//   needs no clearing pass: a wrap flag marks which entries hold written bits,
//   so the block accepts samples right after reset. When the receiver stalls,
//   the result is held in the output register and up to two more samples wait
//   in the queue before samples.ready drops.
module windowed_miss_counter
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    wmc_in_if.sink                           samples,
    wmc_out_if.source                        results
);

    wmc_pkg::cfg_write_t cfg;
    wmc_pkg::q_slot_t    q_push;
    wmc_pkg::q_slot_t    q_head;
    logic                q_space;
    logic                q_pop;

    // Bundle the configuration write for both ends.
    assign cfg.en    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    wmc_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .samples (samples),
        .q_space (q_space),
        .q_push  (q_push)
    );

    wmc_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .space (q_space),
        .head  (q_head),
        .pop   (q_pop)
    );

    wmc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (q_head),
        .pop     (q_pop),
        .results (results)
    );

endmodule

FILE: rtl/wmc_front.sv
// Front end: holds the miss threshold, accepts requests and classifies each
// latency as a miss or a hit. Depends on wmc_pkg and wmc_in_if.
module wmc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  wmc_pkg::cfg_write_t cfg,
    wmc_in_if.sink              samples,
    input  logic                q_space,
    output wmc_pkg::q_slot_t    q_push
);

    logic [wmc_pkg::LAT_W-1:0] threshold_reg;
    logic [wmc_pkg::LAT_W-1:0] threshold_next;

    // Threshold register write.
    always_comb
    begin
        threshold_next = threshold_reg;
        if (cfg.en && cfg.index == wmc_pkg::REG_MISS_THRESHOLD)
        begin
            threshold_next = cfg.data[wmc_pkg::LAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // Accept while the queue has room, classify on the way in.
    assign samples.ready      = q_space;
    assign q_push.valid       = samples.valid && q_space;
    assign q_push.entry.start = samples.start_req;
    assign q_push.entry.miss  = (samples.latency >= threshold_reg);

endmodule

FILE: rtl/wmc_queue.sv
// Short queue between the front and the back end of the windowed miss counter.
// Depends on wmc_pkg.
module wmc_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  wmc_pkg::q_slot_t push,
    output logic             space,
    output wmc_pkg::q_slot_t head,
    input  logic             pop
);

    wmc_pkg::q_entry_t             slot_reg [wmc_pkg::QUEUE_DEPTH];
    logic [wmc_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [wmc_pkg::Q_PTR_W-1:0]   wr_ptr_next;
    logic [wmc_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [wmc_pkg::Q_PTR_W-1:0]   rd_ptr_next;
    logic [wmc_pkg::Q_CNT_W-1:0]   count_reg;
    logic [wmc_pkg::Q_CNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign space      = (count_reg < wmc_pkg::Q_CNT_W'(wmc_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && space;
    assign do_pop     = pop && head.valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == wmc_pkg::Q_PTR_W'(wmc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == wmc_pkg::Q_PTR_W'(wmc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wmc_pkg::Q_CNT_W'(wmc_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");

    // An empty queue has its pointers equal.
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

    // A push on a full queue is never attempted by the front end.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> space)
        else $error("push into a full queue");

endmodule

FILE: rtl/wmc_back.sv
// Back end: miss ring, window count, peak, sample count and finish state,
// plus the output register. Depends on wmc_pkg and wmc_out_if.
module wmc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  wmc_pkg::cfg_write_t cfg,
    input  wmc_pkg::q_slot_t    head,
    output logic                pop,
    wmc_out_if.source           results
);

    // Configuration.
    logic [wmc_pkg::TARGET_W-1:0] target_reg;
    logic [wmc_pkg::TARGET_W-1:0] target_next;
    logic [wmc_pkg::LIMIT_W-1:0]  limit_reg;
    logic [wmc_pkg::LIMIT_W-1:0]  limit_next;

    // Measurement state.
    logic [wmc_pkg::CNT_W-1:0]    window_count_reg;
    logic [wmc_pkg::CNT_W-1:0]    window_count_next;
    logic [wmc_pkg::CNT_W-1:0]    peak_count_reg;
    logic [wmc_pkg::CNT_W-1:0]    peak_count_next;
    logic [wmc_pkg::POS_W-1:0]    ring_pos_reg;
    logic [wmc_pkg::POS_W-1:0]    ring_pos_next;
    logic                         wrapped_reg;
    logic                         wrapped_next;
    logic [wmc_pkg::LIMIT_W-1:0]  samples_reg;
    logic [wmc_pkg::LIMIT_W-1:0]  samples_next;
    logic                         done_reg;
    logic                         done_next;
    wmc_pkg::cause_t              cause_reg;
    wmc_pkg::cause_t              cause_next;

    // Output register.
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [wmc_pkg::OUT_CNT_W-1:0] out_window_reg;
    logic [wmc_pkg::OUT_CNT_W-1:0] out_peak_reg;
    logic                         out_finished_reg;
    wmc_pkg::cause_t              out_cause_reg;

    // Ring memory with a registered read of the entry at the current position.
    logic                         ring_mem [wmc_pkg::WINDOW];
    logic                         ring_rd_reg;
    logic                         ring_we;

    // Values after a start request has been applied.
    logic                         start;
    logic [wmc_pkg::CNT_W-1:0]    eff_window;
    logic [wmc_pkg::CNT_W-1:0]    eff_peak;
    logic [wmc_pkg::POS_W-1:0]    eff_pos;
    logic                         eff_wrapped;
    logic [wmc_pkg::LIMIT_W-1:0]  eff_samples;
    logic                         eff_done;
    logic                         old_bit;
    logic [wmc_pkg::CNT_W-1:0]    new_window;

    // Configuration register writes.
    always_comb
    begin
        target_next = target_reg;
        limit_next  = limit_reg;
        if (cfg.en && cfg.index == wmc_pkg::REG_TARGET_COUNT)
        begin
            target_next = cfg.data[wmc_pkg::TARGET_W-1:0];
        end
        if (cfg.en && cfg.index == wmc_pkg::REG_SAMPLE_LIMIT)
        begin
            limit_next = cfg.data[wmc_pkg::LIMIT_W-1:0];
        end
    end

    assign pop   = head.valid && (!out_valid_reg || results.ready);
    assign start = head.entry.start;

    // A start request clears the measurement before the sample is used.
    assign eff_window  = start ? '0 : window_count_reg;
    assign eff_peak    = start ? '0 : peak_count_reg;
    assign eff_pos     = start ? '0 : ring_pos_reg;
    assign eff_wrapped = start ? 1'b0 : wrapped_reg;
    assign eff_samples = start ? '0 : samples_reg;
    assign eff_done    = start ? 1'b0 : done_reg;

    // Entries not yet written since the last clear read as zero.
    assign old_bit    = eff_wrapped && ring_rd_reg;
    assign new_window = eff_window - wmc_pkg::CNT_W'(old_bit)
                        + wmc_pkg::CNT_W'(head.entry.miss);

    // Measurement update for one request.
    always_comb
    begin
        window_count_next = window_count_reg;
        peak_count_next   = peak_count_reg;
        ring_pos_next     = ring_pos_reg;
        wrapped_next      = wrapped_reg;
        samples_next      = samples_reg;
        done_next         = done_reg;
        cause_next        = cause_reg;
        ring_we           = 1'b0;
        if (pop)
        begin
            window_count_next = eff_window;
            peak_count_next   = eff_peak;
            ring_pos_next     = eff_pos;
            wrapped_next      = eff_wrapped;
            samples_next      = eff_samples;
            done_next         = eff_done;
            cause_next        = start ? wmc_pkg::CAUSE_RUNNING : cause_reg;
            if (!eff_done)
            begin
                if (eff_samples >= limit_reg)
                begin
                    done_next  = 1'b1;
                    cause_next = wmc_pkg::CAUSE_TIMEOUT;
                end
                else
                begin
                    ring_we           = 1'b1;
                    window_count_next = new_window;
                    if (new_window > eff_peak)
                    begin
                        peak_count_next = new_window;
                    end
                    if (wmc_pkg::CMP_W'(new_window) >= wmc_pkg::CMP_W'(target_reg))
                    begin
                        done_next  = 1'b1;
                        cause_next = wmc_pkg::CAUSE_TARGET;
                    end
                    else
                    begin
                        samples_next = eff_samples + 1'b1;
                        if (eff_pos == wmc_pkg::POS_W'(wmc_pkg::WINDOW - 1))
                        begin
                            ring_pos_next = '0;
                            wrapped_next  = 1'b1;
                        end
                        else
                        begin
                            ring_pos_next = eff_pos + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Output handshake: load on pop, drop when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= '0;
            limit_reg        <= '0;
            window_count_reg <= '0;
            peak_count_reg   <= '0;
            ring_pos_reg     <= '0;
            wrapped_reg      <= 1'b0;
            samples_reg      <= '0;
            done_reg         <= 1'b0;
            cause_reg        <= wmc_pkg::CAUSE_RUNNING;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            target_reg       <= target_next;
            limit_reg        <= limit_next;
            window_count_reg <= window_count_next;
            peak_count_reg   <= peak_count_next;
            ring_pos_reg     <= ring_pos_next;
            wrapped_reg      <= wrapped_next;
            samples_reg      <= samples_next;
            done_reg         <= done_next;
            cause_reg        <= cause_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload, captured with the state it reports.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_window_reg   <= window_count_next[wmc_pkg::OUT_CNT_W-1:0];
            out_peak_reg     <= peak_count_next[wmc_pkg::OUT_CNT_W-1:0];
            out_finished_reg <= done_next;
            out_cause_reg    <= cause_next;
        end
    end

    // Ring memory: write the new bit, prefetch the entry at the next position.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[eff_pos] <= head.entry.miss;
        end
        ring_rd_reg <= ring_mem[ring_pos_next];
    end

    assign results.valid         = out_valid_reg;
    assign results.window_misses = out_window_reg;
    assign results.peak_misses   = out_peak_reg;
    assign results.finished      = out_finished_reg;
    assign results.finish_cause  = out_cause_reg;

    // The window count never exceeds the peak since the last start.
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        window_count_reg <= peak_count_reg)
        else $error("window count above peak");

    // A finished measurement carries a cause, a running one does not.
    a_cause_match: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg == (cause_reg != wmc_pkg::CAUSE_RUNNING))
        else $error("finish flag and cause disagree");

    // The ring position stays inside the window.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_pos_reg <= wmc_pkg::POS_W'(wmc_pkg::WINDOW - 1))
        else $error("ring position outside window");

    // After a start request at most one sample has been counted.
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && start) |=> (samples_reg <= wmc_pkg::LIMIT_W'(1)))
        else $error("start request did not clear the sample count");

endmodule
